[src/hps_pkg.sv]
// Package for the +IPD / HTTP path splitter: shared types, byte constants,
// marker tables and the byte classifier. No dependencies.
package hps_pkg;

  localparam int MAX_PARTS_DEF = 8;
  localparam int PART_LEN_DEF  = 16;
  localparam int LINK_LEN_DEF  = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_H     = 8'h48;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_READ = 1'b1
  } hps_req_e;

  typedef enum logic {
    RK_SUMMARY = 1'b0,
    RK_READ    = 1'b1
  } hps_kind_e;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_NO_IPD   = 2'd1,
    ST_NO_COLON = 2'd2,
    ST_NO_SLASH = 2'd3
  } hps_status_e;

  typedef enum logic [2:0] {
    CC_NUL   = 3'd0,
    CC_SLASH = 3'd1,
    CC_EOL   = 3'd2,
    CC_QUERY = 3'd3,
    CC_SPACE = 3'd4,
    CC_COMMA = 3'd5,
    CC_COLON = 3'd6,
    CC_OTHER = 3'd7
  } hps_cls_e;

  typedef enum logic [6:0] {
    PH_SEEK_IPD    = 7'b0000001,
    PH_LINK        = 7'b0000010,
    PH_SEEK_COLON  = 7'b0000100,
    PH_SEEK_SLASH  = 7'b0001000,
    PH_PATH        = 7'b0010000,
    PH_AFTER_SPACE = 7'b0100000,
    PH_TAIL        = 7'b1000000
  } hps_phase_e;

  typedef struct packed {
    hps_req_e   req;
    logic [7:0] data;
    logic       eof;
    logic [2:0] part_sel;
    logic [3:0] char_sel;
    hps_cls_e   cls;
  } hps_item_t;

  function automatic logic [7:0] ipd_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_PLUS;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h44;
      3'd4:    c = CH_COMMA;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] http_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_H;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = CH_SLASH;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic hps_cls_e classify(input logic [7:0] c);
    hps_cls_e k;
    case (c)
      CH_NUL:       k = CC_NUL;
      CH_SLASH:     k = CC_SLASH;
      CH_CR, CH_LF: k = CC_EOL;
      CH_QUERY,
      CH_AMP:       k = CC_QUERY;
      CH_SPACE:     k = CC_SPACE;
      CH_COMMA:     k = CC_COMMA;
      CH_COLON:     k = CC_COLON;
      default:      k = CC_OTHER;
    endcase
    return k;
  endfunction

endpackage

[src/hps_front.sv]
// Front end: takes requests, classifies the frame byte and queues them in a
// two-entry FIFO for the parser. Depends on hps_pkg.
module hps_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                req_type_i,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_frame_i,
  input  logic [2:0]          part_select_i,
  input  logic [3:0]          char_select_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output hps_pkg::hps_item_t  q_item_o
);
  import hps_pkg::*;

  hps_item_t  entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  hps_item_t  item;

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = entry_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    item.req      = hps_req_e'(req_type_i);
    item.data     = data_byte_i;
    item.eof      = end_of_frame_i;
    item.part_sel = part_select_i;
    item.char_sel = char_select_i;
    item.cls      = classify(data_byte_i);
  end

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= item;
  end

endmodule

[src/hps_back.sv]
// Back end: frame parser state, path part store and the result register.
// Pops classified requests from hps_front. Depends on hps_pkg.
module hps_back #(
  parameter int MAX_PARTS = hps_pkg::MAX_PARTS_DEF,
  parameter int PART_LEN  = hps_pkg::PART_LEN_DEF,
  parameter int LINK_LEN  = hps_pkg::LINK_LEN_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  hps_pkg::hps_item_t  q_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                result_kind_o,
  output logic [1:0]          status_o,
  output logic                is_http_o,
  output logic [3:0]          part_count_o,
  output logic [31:0]         link_chars_o,
  output logic [2:0]          link_length_o,
  output logic [7:0]          part_char_o,
  output logic [3:0]          part_length_o
);
  import hps_pkg::*;

  localparam int PKW = $clog2(MAX_PARTS + 1);
  localparam int PW  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int LW  = $clog2(PART_LEN);
  localparam int CW  = (PART_LEN > 2) ? $clog2(PART_LEN - 1) : 1;
  localparam int LCW = $clog2(LINK_LEN + 1);
  localparam int AW  = PW + CW;
  localparam int SW  = (PKW > 3) ? PKW : 3;
  localparam int CMW = (LW > 4) ? LW : 4;

  // parser state
  hps_phase_e     phase_q, phase_d;
  logic [2:0]     ipd_match_q, ipd_match_d;
  logic [2:0]     http_match_q, http_match_d;
  logic [31:0]    link_store_q, link_store_d;
  logic [LCW-1:0] link_count_q, link_count_d;
  logic [PKW-1:0] parts_kept_q, parts_kept_d;
  logic [PKW-1:0] committed_q, committed_d;
  logic           space_seen_q, space_seen_d;
  logic           http_found_q, http_found_d;
  logic           stopped_q, stopped_d;
  logic           slot_active_q, slot_active_d;
  logic           frame_open_q, frame_open_d;
  logic [LW-1:0]  cur_len_q, cur_len_d;
  logic [LW-1:0]  lengths_q [MAX_PARTS];

  logic [7:0]     mem [2**AW];
  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic           len_we;
  logic [PW-1:0]  len_idx;
  logic [LW-1:0]  len_val;
  logic           do_open, do_append;

  // output register
  logic           out_valid_q;
  hps_kind_e      result_kind_q;
  hps_status_e    status_q;
  logic           is_http_q;
  logic [3:0]     part_count_q;
  logic [31:0]    link_chars_q;
  logic [2:0]     link_length_q;
  logic [3:0]     part_length_q;
  logic           hit_q;
  logic [7:0]     rdata_q;

  logic           produces, pop, push_pop, load;
  logic [PKW-1:0] vis_q, vis_d;
  logic           psel_ok, rd_hit;
  logic [LW-1:0]  rd_len;
  hps_status_e    status_d;

  assign produces  = (q_item_i.req == REQ_READ) || q_item_i.eof;
  assign q_ready_o = !produces || !out_valid_q || out_ready_i;
  assign pop       = q_valid_i && q_ready_o;
  assign push_pop  = pop && (q_item_i.req == REQ_PUSH);
  assign load      = pop && produces;

  // read-back lookup against the current part table
  assign vis_q     = http_found_q ? committed_q : parts_kept_q;
  assign psel_ok   = (SW'(q_item_i.part_sel) < SW'(vis_q)) &&
                     (SW'(q_item_i.part_sel) < SW'(MAX_PARTS));
  assign rd_len    = psel_ok ? lengths_q[PW'(q_item_i.part_sel)] : '0;
  assign rd_hit    = psel_ok && (CMW'(q_item_i.char_sel) < CMW'(rd_len));
  assign mem_raddr = {PW'(q_item_i.part_sel), CW'(q_item_i.char_sel)};

  always_comb begin
    phase_d       = phase_q;
    ipd_match_d   = ipd_match_q;
    http_match_d  = http_match_q;
    link_store_d  = link_store_q;
    link_count_d  = link_count_q;
    parts_kept_d  = parts_kept_q;
    committed_d   = committed_q;
    space_seen_d  = space_seen_q;
    http_found_d  = http_found_q;
    stopped_d     = stopped_q;
    slot_active_d = slot_active_q;
    frame_open_d  = frame_open_q;
    cur_len_d     = cur_len_q;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    len_we        = 1'b0;
    len_idx       = '0;
    len_val       = '0;
    do_open       = 1'b0;
    do_append     = 1'b0;

    if (push_pop) begin
      // first byte of a frame starts from a clean parse state
      if (!frame_open_q) begin
        phase_d       = PH_SEEK_IPD;
        ipd_match_d   = 3'd0;
        http_match_d  = 3'd0;
        link_store_d  = '0;
        link_count_d  = '0;
        parts_kept_d  = '0;
        committed_d   = '0;
        space_seen_d  = 1'b0;
        http_found_d  = 1'b0;
        stopped_d     = 1'b0;
        slot_active_d = 1'b0;
      end
      frame_open_d = !q_item_i.eof;

      if (!stopped_d) begin
        if (q_item_i.cls == CC_NUL) begin
          stopped_d = 1'b1;
        end else begin
          if (space_seen_d && !http_found_d) begin
            if (q_item_i.data == http_char(http_match_d)) begin
              if (http_match_d == 3'd4) begin
                http_found_d = 1'b1;
                http_match_d = 3'd0;
              end else begin
                http_match_d = http_match_d + 3'd1;
              end
            end else begin
              http_match_d = (q_item_i.data == CH_H) ? 3'd1 : 3'd0;
            end
          end

          case (phase_d)
            PH_SEEK_IPD: begin
              if (q_item_i.data == ipd_char(ipd_match_d)) begin
                if (ipd_match_d == 3'd4) begin
                  ipd_match_d = 3'd0;
                  phase_d     = PH_LINK;
                end else begin
                  ipd_match_d = ipd_match_d + 3'd1;
                end
              end else begin
                ipd_match_d = (q_item_i.data == CH_PLUS) ? 3'd1 : 3'd0;
              end
            end
            PH_LINK: begin
              if (q_item_i.cls == CC_COMMA) begin
                phase_d = PH_SEEK_COLON;
              end else begin
                for (int k = 0; k < 4; k++) begin
                  if (4'(link_count_d) == 4'(k)) begin
                    link_store_d[8*k +: 8] = q_item_i.data;
                  end
                end
                link_count_d = link_count_d + LCW'(1);
                if (link_count_d >= LCW'(LINK_LEN)) phase_d = PH_SEEK_COLON;
              end
            end
            PH_SEEK_COLON: begin
              if (q_item_i.cls == CC_COLON) phase_d = PH_SEEK_SLASH;
            end
            PH_SEEK_SLASH: begin
              if (q_item_i.cls == CC_SLASH) begin
                do_open = 1'b1;
                phase_d = PH_PATH;
              end else if (q_item_i.cls == CC_EOL) begin
                stopped_d = 1'b1;
              end
            end
            PH_PATH: begin
              case (q_item_i.cls)
                CC_SLASH: do_open = 1'b1;
                CC_EOL, CC_QUERY: phase_d = PH_TAIL;
                CC_SPACE: begin
                  if (!space_seen_d) begin
                    space_seen_d = 1'b1;
                    committed_d  = parts_kept_d;
                  end
                  phase_d = PH_AFTER_SPACE;
                end
                default: do_append = 1'b1;
              endcase
            end
            PH_AFTER_SPACE: begin
              if (q_item_i.cls == CC_SLASH) begin
                do_open = 1'b1;
                phase_d = PH_PATH;
              end else begin
                phase_d = PH_TAIL;
              end
            end
            default: ;
          endcase

          if (do_open) begin
            if (parts_kept_d < PKW'(MAX_PARTS)) begin
              len_we        = 1'b1;
              len_idx       = parts_kept_d[PW-1:0];
              len_val       = '0;
              parts_kept_d  = parts_kept_d + PKW'(1);
              slot_active_d = 1'b1;
              cur_len_d     = '0;
            end else begin
              slot_active_d = 1'b0;
            end
          end

          // characters past the part length limit are dropped
          if (do_append && slot_active_d && (cur_len_d < LW'(PART_LEN - 1))) begin
            len_idx   = PW'(parts_kept_d - PKW'(1));
            mem_we    = 1'b1;
            mem_waddr = {len_idx, CW'(cur_len_d)};
            len_we    = 1'b1;
            len_val   = cur_len_d + LW'(1);
            cur_len_d = len_val;
          end
        end
      end
    end
  end

  always_comb begin
    case (phase_d)
      PH_SEEK_IPD:            status_d = ST_NO_IPD;
      PH_LINK, PH_SEEK_COLON: status_d = ST_NO_COLON;
      PH_SEEK_SLASH:          status_d = ST_NO_SLASH;
      default:                status_d = ST_VALID;
    endcase
  end

  assign vis_d = http_found_d ? committed_d : parts_kept_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SEEK_IPD;
      ipd_match_q   <= 3'd0;
      http_match_q  <= 3'd0;
      link_store_q  <= '0;
      link_count_q  <= '0;
      parts_kept_q  <= '0;
      committed_q   <= '0;
      space_seen_q  <= 1'b0;
      http_found_q  <= 1'b0;
      stopped_q     <= 1'b0;
      slot_active_q <= 1'b0;
      frame_open_q  <= 1'b0;
      cur_len_q     <= '0;
      for (int i = 0; i < MAX_PARTS; i++) lengths_q[i] <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      ipd_match_q   <= ipd_match_d;
      http_match_q  <= http_match_d;
      link_store_q  <= link_store_d;
      link_count_q  <= link_count_d;
      parts_kept_q  <= parts_kept_d;
      committed_q   <= committed_d;
      space_seen_q  <= space_seen_d;
      http_found_q  <= http_found_d;
      stopped_q     <= stopped_d;
      slot_active_q <= slot_active_d;
      frame_open_q  <= frame_open_d;
      cur_len_q     <= cur_len_d;
      if (len_we) lengths_q[len_idx] <= len_val;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // part store; read data is registered with the result
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= q_item_i.data;
    if (load && (q_item_i.req == REQ_READ)) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (q_item_i.req == REQ_READ) begin
        result_kind_q <= RK_READ;
        status_q      <= ST_VALID;
        is_http_q     <= 1'b0;
        part_count_q  <= 4'd0;
        link_chars_q  <= '0;
        link_length_q <= 3'd0;
        part_length_q <= 4'(rd_len);
        hit_q         <= rd_hit;
      end else begin
        result_kind_q <= RK_SUMMARY;
        status_q      <= status_d;
        is_http_q     <= http_found_d;
        part_count_q  <= 4'(vis_d);
        link_chars_q  <= link_store_d;
        link_length_q <= 3'(link_count_d);
        part_length_q <= 4'd0;
        hit_q         <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = result_kind_q;
  assign status_o      = status_q;
  assign is_http_o     = is_http_q;
  assign part_count_o  = part_count_q;
  assign link_chars_o  = link_chars_q;
  assign link_length_o = link_length_q;
  assign part_char_o   = hit_q ? rdata_q : 8'h00;
  assign part_length_o = part_length_q;

`ifndef SYNTHESIS
  a_kept_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    parts_kept_q <= PKW'(MAX_PARTS))
    else $error("part count above limit");
  a_commit_le_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    committed_q <= parts_kept_q)
    else $error("committed parts exceed kept parts");
  a_slot_has_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_active_q |-> (parts_kept_q != '0))
    else $error("active slot without an open part");
  a_link_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_count_q <= LCW'(LINK_LEN))
    else $error("link count above limit");
  a_stop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stopped_q && frame_open_q) |=> $stable(phase_q))
    else $error("phase moved after the frame was stopped");
`endif

endmodule

[src/at_ipd_http_path_splitter.sv]
// A request passes through the front FIFO and then the output register before its result shows.
// Throughput: one request per cycle, frame bytes and read-backs alike; the
// front FIFO (two entries) and the output register let either side stall.
// Reset clears all parse state and handshakes at once; no clearing pass.
// Part characters are read only below the stored length of the part.
// Top level: instantiates hps_front and hps_back; depends on hps_pkg.
module at_ipd_http_path_splitter #(
  parameter int MAX_PARTS = hps_pkg::MAX_PARTS_DEF,
  parameter int PART_LEN  = hps_pkg::PART_LEN_DEF,
  parameter int LINK_LEN  = hps_pkg::LINK_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_frame_i,
  input  logic [2:0]  part_select_i,
  input  logic [3:0]  char_select_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [1:0]  status_o,
  output logic        is_http_o,
  output logic [3:0]  part_count_o,
  output logic [31:0] link_chars_o,
  output logic [2:0]  link_length_o,
  output logic [7:0]  part_char_o,
  output logic [3:0]  part_length_o
);
  import hps_pkg::*;

  logic      q_valid, q_ready;
  hps_item_t q_item;

  hps_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .data_byte_i    (data_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .part_select_i  (part_select_i),
    .char_select_i  (char_select_i),
    .q_valid_o      (q_valid),
    .q_ready_i      (q_ready),
    .q_item_o       (q_item)
  );

  hps_back #(
    .MAX_PARTS (MAX_PARTS),
    .PART_LEN  (PART_LEN),
    .LINK_LEN  (LINK_LEN)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_item_i      (q_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .status_o      (status_o),
    .is_http_o     (is_http_o),
    .part_count_o  (part_count_o),
    .link_chars_o  (link_chars_o),
    .link_length_o (link_length_o),
    .part_char_o   (part_char_o),
    .part_length_o (part_length_o)
  );

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for at_ipd_http_path_splitter: random modem frames and
// part read-backs, predicted in-bench and compared per field. Depends on hps_pkg.
module testbench;
  import hps_pkg::*;

  localparam int NPARTS = MAX_PARTS_DEF;
  localparam int PLEN   = PART_LEN_DEF;
  localparam int LLEN   = LINK_LEN_DEF;
  localparam int ITEM_GOAL = 1850;
  localparam logic [39:0] IPD_TAG  = "+IPD,";
  localparam logic [39:0] HTTP_TAG = "HTTP/";
  localparam string WORD_CHARS = "abcdefghijklmnopqrstuvwxyz0123456789-_.";

  typedef struct packed {
    hps_req_e   req;
    logic [7:0] data;
    logic       eof;
    logic [2:0] psel;
    logic [3:0] csel;
    logic       drain;
  } req_item_t;

  typedef struct packed {
    hps_kind_e   kind;
    hps_status_e status;
    logic        http;
    logic [3:0]  parts;
    logic [31:0] link;
    logic [2:0]  link_len;
    logic [7:0]  ch;
    logic [3:0]  plen;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic        req_type = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_frame = 1'b0;
  logic [2:0]  part_select = 3'd0;
  logic [3:0]  char_select = 4'd0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic        result_kind_o;
  logic [1:0]  status_o;
  logic        is_http_o;
  logic [3:0]  part_count_o;
  logic [31:0] link_chars_o;
  logic [2:0]  link_length_o;
  logic [7:0]  part_char_o;
  logic [3:0]  part_length_o;

  at_ipd_http_path_splitter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type),
    .data_byte_i    (data_byte),
    .end_of_frame_i (end_of_frame),
    .part_select_i  (part_select),
    .char_select_i  (char_select),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .result_kind_o  (result_kind_o),
    .status_o       (status_o),
    .is_http_o      (is_http_o),
    .part_count_o   (part_count_o),
    .link_chars_o   (link_chars_o),
    .link_length_o  (link_length_o),
    .part_char_o    (part_char_o),
    .part_length_o  (part_length_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------- parser prediction ----------------
  hps_phase_e  pr_phase;
  int          ipd_hits, http_hits, link_cnt, path_cnt, path_cnt_at_space;
  logic [31:0] link_word;
  logic [7:0]  path_chars [NPARTS][PLEN];
  logic [3:0]  path_len [NPARTS];
  bit          got_space, got_http, halted, slot_open, in_frame;

  result_t     expected_results [$];

  function automatic void start_frame();
    pr_phase = PH_SEEK_IPD;
    ipd_hits = 0;
    http_hits = 0;
    link_word = '0;
    link_cnt = 0;
    path_cnt = 0;
    path_cnt_at_space = 0;
    got_space = 0;
    got_http = 0;
    halted = 0;
    slot_open = 0;
    in_frame = 1;
  endfunction

  function automatic void open_part();
    if (path_cnt < NPARTS) begin
      path_len[path_cnt] = '0;
      path_cnt++;
      slot_open = 1;
    end else begin
      slot_open = 0;
    end
  endfunction

  function automatic void feed_byte(logic [7:0] c);
    int idx;
    if (c == CH_NUL) begin
      halted = 1;
      return;
    end
    // "HTTP/" is hunted anywhere after the first path-ending space
    if (got_space && !got_http) begin
      if (c == HTTP_TAG[39 - 8 * http_hits -: 8]) begin
        http_hits++;
        if (http_hits >= 5) begin
          got_http = 1;
          http_hits = 0;
        end
      end else begin
        http_hits = (c == CH_H) ? 1 : 0;
      end
    end
    case (pr_phase)
      PH_SEEK_IPD: begin
        if (c == IPD_TAG[39 - 8 * ipd_hits -: 8]) begin
          ipd_hits++;
          if (ipd_hits >= 5) begin
            ipd_hits = 0;
            pr_phase = PH_LINK;
          end
        end else begin
          ipd_hits = (c == CH_PLUS) ? 1 : 0;
        end
      end
      PH_LINK: begin
        if (c == CH_COMMA) begin
          pr_phase = PH_SEEK_COLON;
        end else begin
          if (link_cnt < 4) link_word[8 * link_cnt +: 8] = c;
          link_cnt++;
          if (link_cnt >= LLEN) pr_phase = PH_SEEK_COLON;
        end
      end
      PH_SEEK_COLON: begin
        if (c == CH_COLON) pr_phase = PH_SEEK_SLASH;
      end
      PH_SEEK_SLASH: begin
        if (c == CH_SLASH) begin
          open_part();
          pr_phase = PH_PATH;
        end else if (c == CH_CR || c == CH_LF) begin
          halted = 1;
        end
      end
      PH_PATH: begin
        if (c == CH_SLASH) begin
          open_part();
        end else if (c == CH_CR || c == CH_LF || c == CH_QUERY || c == CH_AMP) begin
          pr_phase = PH_TAIL;
        end else if (c == CH_SPACE) begin
          if (!got_space) begin
            got_space = 1;
            path_cnt_at_space = path_cnt;
          end
          pr_phase = PH_AFTER_SPACE;
        end else if (slot_open && path_cnt > 0 && path_cnt <= NPARTS) begin
          idx = path_cnt - 1;
          if (path_len[idx] < PLEN - 1) begin
            path_chars[idx][path_len[idx]] = c;
            path_len[idx] = path_len[idx] + 4'd1;
          end
        end
      end
      PH_AFTER_SPACE: begin
        if (c == CH_SLASH) begin
          open_part();
          pr_phase = PH_PATH;
        end else begin
          pr_phase = PH_TAIL;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_request(req_item_t it);
    result_t r;
    int shown;
    r = '0;
    if (it.req == REQ_READ) begin
      shown = got_http ? path_cnt_at_space : path_cnt;
      r.kind = RK_READ;
      if (it.psel < shown) begin
        r.plen = path_len[it.psel];
        if (it.csel < path_len[it.psel]) r.ch = path_chars[it.psel][it.csel];
      end
      expected_results.push_back(r);
      return;
    end
    if (!in_frame) start_frame();
    if (!halted) feed_byte(it.data);
    if (!it.eof) return;
    shown = got_http ? path_cnt_at_space : path_cnt;
    r.kind = RK_SUMMARY;
    case (pr_phase)
      PH_SEEK_IPD:                r.status = ST_NO_IPD;
      PH_LINK, PH_SEEK_COLON:     r.status = ST_NO_COLON;
      PH_SEEK_SLASH:              r.status = ST_NO_SLASH;
      default:                    r.status = ST_VALID;
    endcase
    r.http = got_http;
    r.parts = 4'(shown);
    r.link = link_word;
    r.link_len = 3'(link_cnt);
    in_frame = 0;
    expected_results.push_back(r);
  endfunction

  // ---------------- stimulus ----------------
  req_item_t  pending [$];
  logic [7:0] frame_buf [$];
  bit         drain_next;
  int         item_total, accepted;
  bit         failed, calm;

  task automatic add_item(hps_req_e req, logic [7:0] data, logic eof,
                          logic [2:0] psel, logic [3:0] csel);
    req_item_t it;
    it.req = req;
    it.data = data;
    it.eof = eof;
    it.psel = psel;
    it.csel = csel;
    it.drain = drain_next;
    drain_next = 0;
    pending.push_back(it);
    item_total++;
  endtask

  task automatic add_read(logic [2:0] psel, logic [3:0] csel);
    add_item(REQ_READ, 8'($urandom), 1'($urandom), psel, csel);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] word_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(1, 255));
    return WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)];
  endfunction

  // parts separated by '/', the leading slash is the caller's
  task automatic put_path();
    int nparts, plen;
    nparts = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 11) : $urandom_range(1, 4);
    for (int k = 0; k < nparts; k++) begin
      if (k > 0) frame_buf.push_back(CH_SLASH);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 6);
      repeat (plen) frame_buf.push_back(word_char());
    end
  endtask

  task automatic flush_frame(bit mix);
    int n;
    n = frame_buf.size();
    for (int i = 0; i < n; i++) begin
      if (mix && $urandom_range(0, 29) == 0)
        add_read(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
      add_item(REQ_PUSH, frame_buf[i], i == n - 1, 3'($urandom), 4'($urandom));
    end
    frame_buf.delete();
  endtask

  task automatic build_frame();
    repeat ($urandom_range(0, 2)) frame_buf.push_back(8'($urandom_range(1, 255)));
    case ($urandom_range(0, 15))
      0:       ;
      1:       put_text("+IP");
      2:       put_text("++IPD,");
      3:       put_text("+I+IPD,");
      default: put_text("+IPD,");
    endcase
    repeat ($urandom_range(0, 5))
      frame_buf.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                                        : 8'($urandom_range(8'h30, 8'h39)));
    if ($urandom_range(0, 3) != 0) frame_buf.push_back(CH_COMMA);
    repeat ($urandom_range(0, 3)) frame_buf.push_back(8'($urandom_range(8'h30, 8'h39)));
    if ($urandom_range(0, 15) != 0) frame_buf.push_back(CH_COLON);
    case ($urandom_range(0, 4))
      0:       put_text("GET ");
      1:       put_text("POST ");
      2:       repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom_range(1, 255)));
      default: ;
    endcase
    if ($urandom_range(0, 19) == 0) frame_buf.push_back(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
    if ($urandom_range(0, 15) != 0) begin
      frame_buf.push_back(CH_SLASH);
      put_path();
      case ($urandom_range(0, 7))
        0, 1, 2: begin
          frame_buf.push_back(CH_SPACE);
          case ($urandom_range(0, 7))
            0: put_text("HTTP/1.1\r\n");
            1: begin
              frame_buf.push_back(CH_SLASH);
              put_path();
              put_text(" HTTP/1.0");
            end
            2: put_text("HTTX/1.1");
            3: put_text("HHTTP/1.1");
            4: put_text("x HTTP/");
            5: begin
              put_text("HT");
              frame_buf.push_back(CH_NUL);
              put_text("TP/");
            end
            6: frame_buf.push_back(CH_SLASH);
            default: repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom_range(1, 255)));
          endcase
        end
        3: put_text("?q=1&r");
        4: put_text("&z HTTP/");
        5: put_text("\r\n");
        6: begin
          frame_buf.push_back(CH_NUL);
          repeat ($urandom_range(0, 4)) frame_buf.push_back(8'($urandom));
        end
        default: ;
      endcase
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom));
    if (frame_buf.size() == 0) frame_buf.push_back(8'($urandom));
    flush_frame(1);
    repeat ($urandom_range(0, 8))
      add_read(3'($urandom_range(0, 7)),
               ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 6)));
  endtask

  // ---------------- request driver ----------------
  req_item_t cur;
  int        gap_left;
  bit        gaps_on = 1;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        parse_request(cur);
        accepted++;
      end
      calm = (pending.size() < 150);
      if (!in_valid || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending[0].drain && expected_results.size() != 0) begin
          in_valid <= 1'b0;
        end else if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else begin
          cur = pending.pop_front();
          req_type <= cur.req;
          data_byte <= cur.data;
          end_of_frame <= cur.eof;
          part_select <= cur.psel;
          char_select <= cur.csel;
          in_valid <= 1'b1;
        end
      end
      if ($urandom_range(0, 149) == 0) gaps_on = !gaps_on;
    end
  end

  // ---------------- result monitor ----------------
  int stall_left;
  bit stalls_on = 1;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      failed = 1;
    end
  endfunction

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with nothing expected: kind %0h status %0h part_char %0h",
               $time, result_kind_o, status_o, part_char_o);
      failed = 1;
      return;
    end
    want = expected_results.pop_front();
    check_field("result_kind", 32'(want.kind), 32'(result_kind_o));
    check_field("status", 32'(want.status), 32'(status_o));
    check_field("is_http", 32'(want.http), 32'(is_http_o));
    check_field("part_count", 32'(want.parts), 32'(part_count_o));
    check_field("link_chars", want.link, link_chars_o);
    check_field("link_length", 32'(want.link_len), 32'(link_length_o));
    check_field("part_char", 32'(want.ch), 32'(part_char_o));
    check_field("part_length", 32'(want.plen), 32'(part_length_o));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) check_result();
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stalls_on && !calm && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if ($urandom_range(0, 149) == 0) stalls_on = !stalls_on;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    start_frame();
    in_frame = 0;
    for (int p = 0; p < NPARTS; p++) begin
      path_len[p] = '0;
      for (int k = 0; k < PLEN; k++) path_chars[p][k] = '0;
    end

    // directed: one HTTP request line, read-backs at the index extremes,
    // a frame that is only a zero byte, a frame with no marker
    put_text("+IPD,1:/a/b HTTP/");
    flush_frame(0);
    add_read(3'd0, 4'd0);
    add_read(3'd1, 4'd0);
    add_read(3'd1, 4'd1);
    add_read(3'd7, 4'd15);
    frame_buf.push_back(CH_NUL);
    flush_frame(0);
    frame_buf.push_back(8'hFF);
    flush_frame(0);

    drain_next = 1;
    while (item_total < ITEM_GOAL) begin
      if ($urandom_range(0, 24) == 0) drain_next = 1;
      build_frame();
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (accepted != item_total) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
src/hps_pkg.sv
src/hps_front.sv
src/hps_back.sv
src/at_ipd_http_path_splitter.sv
dv/testbench.sv
